// ===== design/lrbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrbp_pkg: shared types and constants of the luma to raw10 packer
// Register codes, output modes, the configuration bundle and the byte command
// that travels from the classifier to the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrbp_pkg;

  localparam int DIM_W      = 14;            // size and position fields
  localparam int ACC_W      = 2 * DIM_W + 1; // scaling accumulators
  localparam int BYTE_W     = 8;
  localparam int GRP_N      = 4;             // picks per RAW10 group
  localparam int CNT_W      = 3;             // bytes per command, up to GRP_N + 1
  localparam int CFG_IDX_W  = 3;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_SRC_HEIGHT = 3'd2,
    REG_SRC_STRIDE = 3'd3,
    REG_OUT_WIDTH  = 3'd4,
    REG_OUT_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    MODE_RAW_SENSOR = 1'b0,
    MODE_RAW10      = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e mode;
    dim_t  src_width;
    dim_t  src_height;
    dim_t  src_stride;
    dim_t  dst_width;
    dim_t  dst_height;
  } cfg_t;

  // Bytes at or above GRP_N, and unused data slots, go out as zero.
  typedef struct packed {
    byte_t [GRP_N-1:0] data;
    logic [CNT_W-1:0]  nbytes;
    logic              row_end;
    logic              frame_end;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/luma_to_raw10_bayer_packer_top.sv =====
// ----------------------------------------------------------------------------
// luma_to_raw10_bayer_packer_top: luma to raw byte packer with downscaling
// Nearest-neighbour downscaler that packs picked luma into RAW10 or 16-bit
// raw sensor byte streams.
// ----------------------------------------------------------------------------
// Luma bytes enter in raster order, src_stride per source row, through a
// push/full queue port; packed bytes leave through an empty/pop queue port,
// one byte per transaction, with row_end, frame_end and last flags. Output
// column x takes source column x*src_width/dst_width and output row y takes
// source row y*src_height/dst_height. In raw sensor mode every pick gives
// two bytes (luma<<2, low byte first); in RAW10 mode picks are grouped by
// four and sent as four bytes plus a zero byte, a short group at row end as
// n bytes plus a zero byte. Rate: the classifier takes one item per cycle
// while the command queue is not full, and the serializer sends one byte
// per cycle while the output register is free or popped. A four-entry
// command queue between the two absorbs bursts. Configuration is written
// over the cfg channel, always ready; the user must write it only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_to_raw10_bayer_packer_top
  import lrbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input queue side
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [BYTE_W-1:0]    luma,
  // result queue side
  output logic                      empty,
  input  wire logic                 pop,
  output logic [BYTE_W-1:0]         out_byte,
  output logic                      row_end,
  output logic                      frame_end,
  output logic                      last,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic accept;
  logic cmd_valid, q_not_empty, q_pop;
  cmd_t cmd, q_head;

  // Registers take every write at once.
  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_RAW10;
      cfg.src_width  <= dim_t'(640);
      cfg.src_height <= dim_t'(480);
      cfg.src_stride <= dim_t'(640);
      cfg.dst_width  <= dim_t'(640);
      cfg.dst_height <= dim_t'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:       cfg.mode       <= mode_e'(cfg_data[0]);
        REG_SRC_WIDTH:  cfg.src_width  <= cfg_data;
        REG_SRC_HEIGHT: cfg.src_height <= cfg_data;
        REG_SRC_STRIDE: cfg.src_stride <= cfg_data;
        REG_OUT_WIDTH:  cfg.dst_width  <= cfg_data;
        REG_OUT_HEIGHT: cfg.dst_height <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front: classify each accepted item and build its byte command.
  lrbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (accept),
    .luma       (luma),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  // Hold commands until the serializer drains them; full back-pressures input.
  lrbp_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_valid),
    .wr_cmd    (cmd),
    .rd_en     (q_pop),
    .rd_cmd    (q_head),
    .not_empty (q_not_empty),
    .full      (full)
  );

  // Back: advance one byte per cycle into the output register while it is free or popped.
  lrbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_not_empty),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .row_end    (row_end),
    .frame_end  (frame_end),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== design/lrbp_front.sv =====
// ----------------------------------------------------------------------------
// lrbp_front: position tracking and pick classification
// Track source and output positions, decide nearest-neighbour picks with
// addition-only accumulators; one command per raw pick or RAW10 group flush.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbp_front
  import lrbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  item_valid,
  input  wire byte_t luma,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  function automatic dim_t dim_clamp(input dim_t v, input int max_v);
    dim_t r;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (32'(v) > max_v) begin
      r = dim_t'(max_v);
    end else begin
      r = v;
    end
    return r;
  endfunction

  dim_t src_col, src_row, out_col, out_row;
  acc_t col_base, col_target, row_base, row_target;
  byte_t [GRP_N-1:0] group_bytes;
  logic [CNT_W-1:0] group_fill;

  dim_t sw, sh, st, ow, oh, ow_c, oh_c;
  logic col_in, col_pick, row_pick, emit, flush, row_done, frame_done;
  logic re, fe;
  logic [DIM_W:0] out_col_inc, out_row_inc;
  logic [CNT_W-1:0] fill_inc;
  byte_t [GRP_N-1:0] grp_next;

  always_comb begin
    sw   = dim_clamp(cfg.src_width, MAX_WIDTH);
    sh   = dim_clamp(cfg.src_height, MAX_HEIGHT);
    st   = (cfg.src_stride < sw) ? sw : cfg.src_stride;
    ow_c = dim_clamp(cfg.dst_width, MAX_WIDTH);
    oh_c = dim_clamp(cfg.dst_height, MAX_HEIGHT);
    ow   = (ow_c > sw) ? sw : ow_c;
    oh   = (oh_c > sh) ? sh : oh_c;

    col_in   = src_col < sw;
    col_pick = col_in && (out_col < ow) && (col_target < col_base + ACC_W'(ow));
    row_pick = (out_row < oh) && (row_target < row_base + ACC_W'(oh));
    emit     = col_pick && row_pick;

    out_col_inc = {1'b0, out_col} + 1'b1;
    out_row_inc = {1'b0, out_row} + 1'b1;
    re = out_col_inc >= {1'b0, ow};
    fe = re && (out_row_inc >= {1'b0, oh});

    grp_next = group_bytes;
    grp_next[group_fill[1:0]] = luma;
    fill_inc = group_fill + 1'b1;
    flush    = (fill_inc >= CNT_W'(GRP_N)) || re;

    row_done   = ({1'b0, src_col} + 1'b1) >= {1'b0, st};
    frame_done = ({1'b0, src_row} + 1'b1) >= {1'b0, sh};

    cmd.row_end   = re;
    cmd.frame_end = fe;
    cmd.data      = '0;
    if (cfg.mode == MODE_RAW_SENSOR) begin
      cmd.data[0] = {luma[5:0], 2'b00};
      cmd.data[1] = {6'b0, luma[7:6]};
      cmd.nbytes  = CNT_W'(2);
    end else begin
      for (int i = 0; i < GRP_N; i++) begin
        if (CNT_W'(i) < fill_inc) begin
          cmd.data[i] = grp_next[i];
        end
      end
      cmd.nbytes = fill_inc + 1'b1;
    end
    cmd_valid = item_valid && emit && ((cfg.mode == MODE_RAW_SENSOR) || flush);
  end

  // Group storage holds payload only; entries past the fill are never shown.
  always_ff @(posedge clk) begin
    if (item_valid && emit && (cfg.mode == MODE_RAW10)) begin
      group_bytes <= grp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col    <= '0;
      src_row    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      col_base   <= '0;
      col_target <= '0;
      row_base   <= '0;
      row_target <= '0;
      group_fill <= '0;
    end else if (item_valid) begin
      if (col_in) begin
        if (col_pick) begin
          out_col    <= out_col_inc[DIM_W-1:0];
          col_target <= col_target + ACC_W'(sw);
        end
        col_base <= col_base + ACC_W'(ow);
      end
      if (emit && (cfg.mode == MODE_RAW10)) begin
        group_fill <= flush ? '0 : fill_inc;
      end
      if (row_done) begin
        src_col    <= '0;
        out_col    <= '0;
        col_base   <= '0;
        col_target <= '0;
        group_fill <= '0;
        if (frame_done) begin
          src_row    <= '0;
          out_row    <= '0;
          row_base   <= '0;
          row_target <= '0;
        end else begin
          src_row  <= src_row + 1'b1;
          row_base <= row_base + ACC_W'(oh);
          if (row_pick) begin
            out_row    <= out_row_inc[DIM_W-1:0];
            row_target <= row_target + ACC_W'(sh);
          end
        end
      end else begin
        src_col <= src_col + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lrbp_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// lrbp_cmd_queue: short command queue
// Decouple the classifier from the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbp_cmd_queue
  import lrbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  input  wire logic rd_en,
  output cmd_t      rd_cmd,
  output logic      not_empty,
  output logic      full
);

  cmd_t entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_CNT_W-1:0] count;

  assign rd_cmd    = entries[rd_ptr];
  assign not_empty = count != '0;
  assign full      = count == CMDQ_CNT_W'(CMDQ_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lrbp_back.sv =====
// ----------------------------------------------------------------------------
// lrbp_back: byte serializer
// Walk the head command out one byte per cycle while the output slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbp_back
  import lrbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic head_valid,
  output logic      head_pop,
  input  wire logic pop,
  output logic      empty,
  output byte_t     out_byte,
  output logic      row_end,
  output logic      frame_end,
  output logic      last
);

  logic [CNT_W-1:0] idx;
  logic out_valid, slot_free, load, is_last;
  byte_t byte_sel;

  always_comb begin
    slot_free = !out_valid || pop;
    load      = slot_free && head_valid;
    is_last   = idx == (head.nbytes - 1'b1);
    byte_sel  = (idx < CNT_W'(GRP_N)) ? head.data[idx[1:0]] : '0;
    head_pop  = load && is_last;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_sel;
      row_end   <= is_last && head.row_end;
      frame_end <= is_last && head.frame_end;
      last      <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= is_last ? '0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
